### design/oct_pkg.sv
// Package for the ordered contact table: word types, command and status
// codes, controller states. No dependencies.
`default_nettype none
package oct_pkg;
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned ENTRY_W = 192;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_LIST      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_END      = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [63:0]        name_high;
    logic [63:0]        name_mid;
    logic [31:0]        name_low;
    logic signed [31:0] phone;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        out_name_high;
    logic [63:0]        out_name_mid;
    logic [31:0]        out_name_low;
    logic signed [31:0] out_phone;
    logic               last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
    S_SCAN_RD, S_SCAN_CHK, S_DEL_RD, S_DEL_WR, S_EMIT, S_OUT_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic idx_zero;
    logic idx_cnt;
    logic idx_inc;
    logic idx_dec;
    logic rd_prev;
    logic rd_next;
    logic rd_idx;
    logic wr_idx_from_rd;
    logic wr_idx_from_in;
    logic wr_back_from_in;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
    logic [1:0] out_status;
    logic out_use_entry;
    logic out_last;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] command;
    logic       full;
    logic       idx_at_cnt;
    logic       idx_zero;
    logic       idx_last;
    logic       match;
    logic       out_busy;
  } sts_t;
endpackage
`default_nettype wire

### design/ordered_contact_table.sv
// Top level of the ordered contact table. Depends on oct_pkg, oct_ctrl,
// oct_datapath and oct_ram.
//
// Holds up to DEPTH contacts in one RAM with a registered read port, one
// command word at a time. Insert back writes the new entry at the end; insert
// front first moves every stored entry up by one (one read and one write per
// moved entry); search and remove walk the table one entry at a time, remove
// then moves the tail up (one read and one write per moved entry); list gives
// one result per stored entry plus the end marker. A result sits in an output
// register; the walk holds while that register is still full.
`default_nettype none
module ordered_contact_table #(
  parameter int unsigned DEPTH = oct_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire oct_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output oct_pkg::out_word_t      out_data
);
  import oct_pkg::*;

  ctl_t ctl;
  sts_t sts;

  oct_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  oct_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_data)
  );
endmodule
`default_nettype wire

### design/oct_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module oct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/oct_datapath.sv
// Datapath: command register, entry count, walk index, entry RAM, result
// register. Depends on oct_pkg and oct_ram.
`default_nettype none
module oct_datapath #(
  parameter int unsigned DEPTH = oct_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire oct_pkg::in_word_t in_word,
  input  wire oct_pkg::ctl_t     ctl,
  output oct_pkg::sts_t          sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output oct_pkg::out_word_t     out_word
);
  import oct_pkg::*;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  in_word_t         cmd_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;
  logic [ENTRY_W-1:0] rdata, wdata;
  logic [CW-1:0]    raddr_w, waddr_w;
  logic             we;

  always_comb begin
    raddr_w = idx_r;
    if (ctl.rd_prev) begin
      raddr_w = idx_r - CW'(1);
    end else if (ctl.rd_next) begin
      raddr_w = idx_r + CW'(1);
    end
    we      = ctl.wr_idx_from_rd | ctl.wr_idx_from_in | ctl.wr_back_from_in;
    waddr_w = ctl.wr_back_from_in ? cnt_r : idx_r;
    wdata   = ctl.wr_idx_from_rd ? rdata
            : {cmd_r.name_high, cmd_r.name_mid, cmd_r.name_low, cmd_r.phone};
  end

  oct_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr_w[AW-1:0]),
    .wdata(wdata),
    .raddr(raddr_w[AW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctl.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    idx_nxt = idx_r;
    if (ctl.idx_zero) begin
      idx_nxt = '0;
    end else if (ctl.idx_cnt) begin
      idx_nxt = cnt_r;
    end else if (ctl.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end else if (ctl.idx_dec) begin
      idx_nxt = idx_r - CW'(1);
    end
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt.status = ctl.out_status;
      out_nxt.last   = ctl.out_last;
      if (ctl.out_use_entry) begin
        {out_nxt.out_name_high, out_nxt.out_name_mid, out_nxt.out_name_low,
         out_nxt.out_phone} = rdata;
      end else begin
        out_nxt.out_name_high = '0;
        out_nxt.out_name_mid  = '0;
        out_nxt.out_name_low  = '0;
        out_nxt.out_phone     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt;
    out_r <= out_nxt;
    if (ctl.load_in) begin
      cmd_r <= in_word;
    end
  end

  always_comb begin
    sts.command    = cmd_r.command;
    sts.full       = (cnt_r == CW'(DEPTH));
    sts.idx_at_cnt = (idx_r == cnt_r);
    sts.idx_zero   = (idx_r == '0);
    sts.idx_last   = (idx_r + CW'(1) == cnt_r);
    sts.match      = (rdata[ENTRY_W-1:32] ==
                      {cmd_r.name_high, cmd_r.name_mid, cmd_r.name_low});
    sts.out_busy   = out_valid_r & ~out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
endmodule
`default_nettype wire

### design/oct_ctrl.sv
// Controller state machine: sequences inserts, walks, shifts and results.
// Depends on oct_pkg.
`default_nettype none
module oct_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire oct_pkg::sts_t sts,
  output oct_pkg::ctl_t      ctl
);
  import oct_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (sts.command)
          CMD_INS_FRONT: state_nxt = sts.full ? S_OUT_WAIT : S_SHIFT_RD;
          CMD_INS_BACK:  state_nxt = sts.full ? S_OUT_WAIT : S_IDLE;
          CMD_REMOVE, CMD_SEARCH, CMD_LIST: state_nxt = S_SCAN_RD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SHIFT_RD: state_nxt = sts.idx_zero ? S_PUT : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_PUT:      state_nxt = S_IDLE;
      S_SCAN_RD: begin
        if (sts.idx_at_cnt) begin
          state_nxt = S_OUT_WAIT;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.command == CMD_LIST) begin
          state_nxt = S_EMIT;
        end else if (sts.match) begin
          if (sts.command == CMD_SEARCH) state_nxt = S_EMIT;
          else state_nxt = S_DEL_RD;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          state_nxt = (sts.command == CMD_LIST) ? S_SCAN_RD : S_IDLE;
        end
      end
      S_DEL_RD: state_nxt = sts.idx_last ? S_IDLE : S_DEL_WR;
      S_DEL_WR: state_nxt = S_DEL_RD;
      S_OUT_WAIT: if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctl.load_in = 1'b1;
      end
      S_DECODE: begin
        case (sts.command)
          CMD_INS_FRONT: ctl.idx_cnt = ~sts.full;
          CMD_INS_BACK: begin
            ctl.wr_back_from_in = ~sts.full;
            ctl.cnt_inc         = ~sts.full;
          end
          default: ctl.idx_zero = 1'b1;
        endcase
      end
      S_SHIFT_RD: ctl.rd_prev = ~sts.idx_zero;
      S_SHIFT_WR: begin
        ctl.wr_idx_from_rd = 1'b1;
        ctl.idx_dec        = 1'b1;
      end
      S_PUT: begin
        ctl.wr_idx_from_in = 1'b1;
        ctl.cnt_inc        = 1'b1;
      end
      S_SCAN_RD: ctl.rd_idx = 1'b1;
      S_SCAN_CHK: begin
        if (sts.command == CMD_LIST || !sts.match) ctl.idx_inc = 1'b1;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          ctl.out_load      = 1'b1;
          ctl.out_status    = ST_OK;
          ctl.out_use_entry = 1'b1;
          ctl.out_last      = (sts.command == CMD_SEARCH);
        end
        // keep the entry on the read port while waiting
        ctl.rd_prev = (sts.command == CMD_LIST);
        ctl.rd_idx  = (sts.command != CMD_LIST);
      end
      S_DEL_RD: begin
        ctl.rd_next = 1'b1;
        ctl.cnt_dec = sts.idx_last;
      end
      S_DEL_WR: begin
        ctl.wr_idx_from_rd = 1'b1;
        ctl.idx_inc        = 1'b1;
      end
      S_OUT_WAIT: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.out_last = 1'b1;
          if (sts.command == CMD_LIST) ctl.out_status = ST_END;
          else if (sts.command == CMD_REMOVE || sts.command == CMD_SEARCH)
            ctl.out_status = ST_NOTFOUND;
          else ctl.out_status = ST_FULL;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### design/oct_checker.sv
// Port-level checks for ordered_contact_table, bound to the top level.
// Depends on oct_pkg.
`default_nettype none
module oct_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire oct_pkg::out_word_t out_data
);
  import oct_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.last)
    else $error("status word without last");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.out_phone == '0)
    else $error("nonzero phone on status word");
endmodule

bind ordered_contact_table oct_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
